[src/hcfc_pkg.sv]
// Shared types and constants of the heating circuit flow controller.
`default_nettype none
package hcfc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int TEMP_W     = 16;
  localparam int VALVE_W    = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_SLOPE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_LEVEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETBACK_AMOUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_MIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_MAX       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_START_OUTDOOR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_NOW       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PREV      = 3'd7;

  // 30.0 degrees and 1.0 degree in 1/16 degree units
  localparam logic signed [15:0] FLOW_HEAT_MIN = 16'sd480;
  localparam logic signed [16:0] START_HYST    = 17'sd16;

  typedef struct packed {
    logic        [11:0] curve_slope;
    logic signed [15:0] curve_level;
    logic        [14:0] setback_amount;
    logic signed [15:0] flow_min;
    logic signed [15:0] flow_max;
    logic signed [15:0] start_outdoor;
    logic        [15:0] gain_now;
    logic signed [16:0] gain_prev;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul_curve;
    logic calc_target;
    logic mul_now;
    logic mul_prev;
    logic calc_drive;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

[src/hcfc_cfg.sv]
// Configuration register file of the heating circuit flow controller.
`default_nettype none
module hcfc_cfg
  import hcfc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.curve_slope    <= 12'd256;
      cfg_r.curve_level    <= 16'sd0;
      cfg_r.setback_amount <= 15'd0;
      cfg_r.flow_min       <= 16'sd0;
      cfg_r.flow_max       <= 16'sd1280;
      cfg_r.start_outdoor  <= 16'sd256;
      cfg_r.gain_now       <= 16'd256;
      cfg_r.gain_prev      <= -17'sd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CURVE_SLOPE:    cfg_r.curve_slope    <= cfg_wdata[11:0];
        CFG_CURVE_LEVEL:    cfg_r.curve_level    <= $signed(cfg_wdata[15:0]);
        CFG_SETBACK_AMOUNT: cfg_r.setback_amount <= cfg_wdata[14:0];
        CFG_FLOW_MIN:       cfg_r.flow_min       <= $signed(cfg_wdata[15:0]);
        CFG_FLOW_MAX:       cfg_r.flow_max       <= $signed(cfg_wdata[15:0]);
        CFG_START_OUTDOOR:  cfg_r.start_outdoor  <= $signed(cfg_wdata[15:0]);
        CFG_GAIN_NOW:       cfg_r.gain_now       <= cfg_wdata[15:0];
        CFG_GAIN_PREV:      cfg_r.gain_prev      <= $signed(cfg_wdata[16:0]);
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[src/hcfc_ctrl.sv]
// Sequencing state machine of the heating circuit flow controller.
`default_nettype none
module hcfc_ctrl
  import hcfc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MULC = 3'd1;
  localparam logic [2:0] S_TGT  = 3'd2;
  localparam logic [2:0] S_MULN = 3'd3;
  localparam logic [2:0] S_MULP = 3'd4;
  localparam logic [2:0] S_SUM  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MULC;
      S_MULC:  state_nxt = S_TGT;
      S_TGT:   state_nxt = S_MULN;
      S_MULN:  state_nxt = S_MULP;
      S_MULP:  state_nxt = S_SUM;
      S_SUM:   state_nxt = S_OUT;
      S_OUT:   if (status.out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd.load        = in_ready && in_valid;
    cmd.mul_curve   = (state_r == S_MULC);
    cmd.calc_target = (state_r == S_TGT);
    cmd.mul_now     = (state_r == S_MULN);
    cmd.mul_prev    = (state_r == S_MULP);
    cmd.calc_drive  = (state_r == S_SUM);
    cmd.out_load    = (state_r == S_OUT) && status.out_free;
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.mul_curve, cmd.calc_target, cmd.mul_now,
              cmd.mul_prev, cmd.calc_drive, cmd.out_load}))
    else $error("more than one datapath command at once");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_MULC))
    else $error("accepted transaction did not start the sequence");

  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && !status.out_free |=> (state_r == S_OUT))
    else $error("result left before the output register was free");

  a_sum_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM) |=> (state_r == S_OUT))
    else $error("sequence skipped the output step");

endmodule
`default_nettype wire

[src/hcfc_dp.sv]
// Datapath of the heating circuit flow controller: shared multiplier, state, output register.
`default_nettype none
module hcfc_dp
  import hcfc_pkg::*;
#(
  parameter int Y_LOW  = 0,
  parameter int Y_HIGH = 25600
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cfg_t                     cfg,
  input  wire cmd_t                     cmd,
  output status_t                       status,
  input  wire logic signed [TEMP_W-1:0] in_room_target,
  input  wire logic signed [TEMP_W-1:0] in_outdoor_now,
  input  wire logic signed [TEMP_W-1:0] in_outdoor_mean,
  input  wire logic signed [TEMP_W-1:0] in_flow_measured,
  input  wire logic                     in_reduced_mode,
  input  wire logic                     in_party_active,
  input  wire logic signed [TEMP_W-1:0] in_frost_threshold,
  input  wire logic                     out_ready,
  output logic                          out_valid,
  output logic signed [TEMP_W-1:0]      out_flow_target,
  output logic        [VALVE_W-1:0]     out_valve_drive,
  output logic                          out_pump_on
);

  localparam logic signed [33:0] Y_LO = 34'(Y_LOW);
  localparam logic signed [33:0] Y_HI = 34'(Y_HIGH);

  // captured transaction
  logic signed [15:0] room_r, outdoor_r, mean_r, flow_r, frost_r;
  logic               setback_r;
  logic signed [16:0] diff_r;

  logic signed [35:0] prod_r, acc_r;
  logic signed [15:0] target_r;
  logic signed [16:0] err_r;

  // controller state
  logic        [VALVE_W-1:0] drive_r;
  logic signed [16:0]        last_err_r;
  logic                      pump_r;

  logic                      out_valid_r;
  logic signed [15:0]        out_target_r;
  logic        [VALVE_W-1:0] out_drive_r;
  logic                      out_pump_r;

  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod_nxt;
  logic signed [23:0] tgt_sum, tgt_clamp;
  logic signed [15:0] target_nxt;
  logic signed [36:0] pi_sum;
  logic signed [32:0] delta;
  logic signed [33:0] y_raw, y_clamp;
  logic               pump_nxt;

  always_comb begin
    unique case (1'b1)
      cmd.mul_now: begin
        mul_a = $signed({err_r[16], err_r});
        mul_b = $signed({2'b00, cfg.gain_now});
      end
      cmd.mul_prev: begin
        mul_a = $signed({last_err_r[16], last_err_r});
        mul_b = $signed({cfg.gain_prev[16], cfg.gain_prev});
      end
      default: begin
        mul_a = $signed({diff_r[16], diff_r});
        mul_b = $signed({6'b000000, cfg.curve_slope});
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // heating curve, setback and flow limits
  always_comb begin
    tgt_sum = 24'(room_r) + 24'(cfg.curve_level) + $signed(prod_r[31:8]);
    if (setback_r) begin
      tgt_sum = tgt_sum - $signed({9'd0, cfg.setback_amount});
    end
    tgt_clamp = tgt_sum;
    if (tgt_clamp < 24'(cfg.flow_min)) tgt_clamp = 24'(cfg.flow_min);
    if (tgt_clamp > 24'(cfg.flow_max)) tgt_clamp = 24'(cfg.flow_max);
    target_nxt = tgt_clamp[15:0];
  end

  // incremental PI step
  always_comb begin
    pi_sum  = 37'(acc_r) + 37'(prod_r);
    delta   = 33'(pi_sum >>> 4);
    y_raw   = $signed({19'd0, drive_r}) + 34'(delta);
    y_clamp = y_raw;
    if (y_clamp < Y_LO) y_clamp = Y_LO;
    if (y_clamp > Y_HI) y_clamp = Y_HI;
  end

  always_comb begin
    priority if ((mean_r < cfg.start_outdoor) && (target_r > FLOW_HEAT_MIN)) begin
      pump_nxt = 1'b1;
    end else if (17'(mean_r) > (17'(cfg.start_outdoor) + START_HYST)) begin
      pump_nxt = 1'b0;
    end else if (outdoor_r < frost_r) begin
      pump_nxt = 1'b1;
    end else begin
      pump_nxt = pump_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      room_r    <= in_room_target;
      outdoor_r <= in_outdoor_now;
      mean_r    <= in_outdoor_mean;
      flow_r    <= in_flow_measured;
      frost_r   <= in_frost_threshold;
      setback_r <= in_reduced_mode && !in_party_active;
      diff_r    <= 17'(in_room_target) - 17'(in_outdoor_now);
    end
    if (cmd.mul_curve || cmd.mul_now || cmd.mul_prev) begin
      prod_r <= prod_nxt;
    end
    if (cmd.mul_prev) begin
      acc_r <= prod_r;
    end
    if (cmd.calc_target) begin
      target_r <= target_nxt;
      err_r    <= 17'(target_nxt) - 17'(flow_r);
    end
    if (cmd.out_load) begin
      out_target_r <= target_r;
      out_drive_r  <= drive_r;
      out_pump_r   <= pump_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r     <= '0;
      last_err_r  <= '0;
      pump_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.calc_drive) begin
        drive_r    <= y_clamp[VALVE_W-1:0];
        last_err_r <= err_r;
        pump_r     <= pump_nxt;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_flow_target = out_target_r;
  assign out_valve_drive = out_drive_r;
  assign out_pump_on     = out_pump_r;

  a_drive_cap: assert property (@(posedge clk) disable iff (!rst_n)
    $signed({19'd0, drive_r}) <= Y_HI || Y_HI < 34'sd0)
    else $error("valve drive above its upper limit");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> status.out_free)
    else $error("output register overwritten while occupied");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.calc_drive |=> $stable(drive_r) && $stable(last_err_r))
    else $error("controller state changed outside the update step");

endmodule
`default_nettype wire

[src/heating_circuit_flow_controller_unit.sv]
// Top level of the heating circuit flow controller.
//
// Usage:
//  - Input channel (in_valid / in_ready): one transaction per sample, with room
//    setpoint, outdoor, mean outdoor, measured flow, frost threshold and flags.
//  - Output channel (out_valid / out_ready): one transaction per sample, with
//    the clamped flow setpoint, the valve command and the pump command.
//  - Configuration port (cfg_we / cfg_index / cfg_wdata): write the curve,
//    limit and gain registers while the block is idle; index 0..7.
//  - Sequence: curve product, target, the two PI products (one per cycle),
//    valve update, then the output register load once that register is
//    free; out_valid is registered from that load. A single shared 18x18
//    multiplier serves all three products; in_ready is high only in idle.
//  - A new sample is taken while the previous result still sits in the
//    output register; if the receiver stalls, the finished sample holds in
//    the datapath and in_ready stays low until the output register frees.
//  - Reset (rst_n low, synchronous) loads the register defaults, clears the
//    valve level, the stored error and the pump state, and empties the output.
`default_nettype none
module heating_circuit_flow_controller_unit
  import hcfc_pkg::*;
#(
  parameter int Y_LOW  = 0,
  parameter int Y_HIGH = 25600
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [TEMP_W-1:0] in_room_target,
  input  wire logic signed [TEMP_W-1:0] in_outdoor_now,
  input  wire logic signed [TEMP_W-1:0] in_outdoor_mean,
  input  wire logic signed [TEMP_W-1:0] in_flow_measured,
  input  wire logic                     in_reduced_mode,
  input  wire logic                     in_party_active,
  input  wire logic signed [TEMP_W-1:0] in_frost_threshold,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [TEMP_W-1:0]      out_flow_target,
  output logic        [VALVE_W-1:0]     out_valve_drive,
  output logic                          out_pump_on
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // register file: hold the settings between samples
  hcfc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // controller: step the datapath through curve, PI and output phases
  hcfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: compute the setpoint, advance the valve level, decide the pump
  hcfc_dp #(
    .Y_LOW  (Y_LOW),
    .Y_HIGH (Y_HIGH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .cmd                (cmd),
    .status             (status),
    .in_room_target     (in_room_target),
    .in_outdoor_now     (in_outdoor_now),
    .in_outdoor_mean    (in_outdoor_mean),
    .in_flow_measured   (in_flow_measured),
    .in_reduced_mode    (in_reduced_mode),
    .in_party_active    (in_party_active),
    .in_frost_threshold (in_frost_threshold),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_flow_target    (out_flow_target),
    .out_valve_drive    (out_valve_drive),
    .out_pump_on        (out_pump_on)
  );

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the heating circuit flow controller.
`timescale 1ns / 1ps
module tb_top;
  import hcfc_pkg::*;

  localparam int VALVE_LOW   = 0;
  localparam int VALVE_HIGH  = 25600;
  localparam int SETTLE_CYC  = 16;         // extra settle time after the last result
  localparam longint TIMEOUT_NS = 64'd5_000_000;

  typedef struct packed {
    logic signed [TEMP_W-1:0] room_target;
    logic signed [TEMP_W-1:0] outdoor_now;
    logic signed [TEMP_W-1:0] outdoor_mean;
    logic signed [TEMP_W-1:0] flow_measured;
    logic                     reduced_mode;
    logic                     party_active;
    logic signed [TEMP_W-1:0] frost_threshold;
  } sample_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] flow_target;
    logic [VALVE_W-1:0]       valve_drive;
    logic                     pump_on;
  } command_t;

  // Shadow copy of the controller: registers, valve integrator, stored error
  // and pump latch, plus the queue of commands still owed by the block.
  class flow_command_scoreboard;
    cfg_t     regs;
    longint   valve_level;
    longint   prev_error;
    bit       pump_latch;
    command_t expected_commands[$];
    int       mismatches;
    int       compared;

    function new();
      regs.curve_slope    = 12'd256;
      regs.curve_level    = 16'sd0;
      regs.setback_amount = 15'd0;
      regs.flow_min       = 16'sd0;
      regs.flow_max       = 16'sd1280;
      regs.start_outdoor  = 16'sd256;
      regs.gain_now       = 16'd256;
      regs.gain_prev      = -17'sd256;
      valve_level = 0;
      prev_error  = 0;
      pump_latch  = 1'b0;
      mismatches  = 0;
      compared    = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CURVE_SLOPE:    regs.curve_slope    = data[11:0];
        CFG_CURVE_LEVEL:    regs.curve_level    = data[15:0];
        CFG_SETBACK_AMOUNT: regs.setback_amount = data[14:0];
        CFG_FLOW_MIN:       regs.flow_min       = data[15:0];
        CFG_FLOW_MAX:       regs.flow_max       = data[15:0];
        CFG_START_OUTDOOR:  regs.start_outdoor  = data[15:0];
        CFG_GAIN_NOW:       regs.gain_now       = data[15:0];
        CFG_GAIN_PREV:      regs.gain_prev      = data[16:0];
        default: ;
      endcase
    endfunction

    // Work out the commands for one accepted sample and advance the state.
    function void note_sample(sample_t s);
      longint   tgt;
      longint   err;
      longint   y;
      longint   slope_term;
      longint   start_lvl;
      longint   mean;
      command_t c;
      slope_term = (longint'(s.room_target) - longint'(s.outdoor_now))
                   * longint'(regs.curve_slope);
      tgt = longint'(s.room_target) + longint'(regs.curve_level) + (slope_term >>> 8);
      if (s.reduced_mode && !s.party_active)
        tgt = tgt - longint'(regs.setback_amount);
      // minimum first, so an inverted pair leaves the maximum in charge
      if (tgt < longint'(regs.flow_min)) tgt = longint'(regs.flow_min);
      if (tgt > longint'(regs.flow_max)) tgt = longint'(regs.flow_max);

      err = tgt - longint'(s.flow_measured);
      y = valve_level + ((longint'(regs.gain_now) * err
                          + longint'(regs.gain_prev) * prev_error) >>> 4);
      if (y < VALVE_LOW)  y = VALVE_LOW;
      if (y > VALVE_HIGH) y = VALVE_HIGH;
      valve_level = y;
      prev_error  = err;

      mean      = longint'(s.outdoor_mean);
      start_lvl = longint'(regs.start_outdoor);
      if (mean < start_lvl && tgt > longint'(FLOW_HEAT_MIN))
        pump_latch = 1'b1;
      else if (mean > start_lvl + longint'(START_HYST))
        pump_latch = 1'b0;
      else if (s.outdoor_now < s.frost_threshold)
        pump_latch = 1'b1;

      c.flow_target = tgt[TEMP_W-1:0];
      c.valve_drive = y[VALVE_W-1:0];
      c.pump_on     = pump_latch;
      expected_commands.push_back(c);
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(command_t got);
      command_t want;
      if (expected_commands.size() == 0) begin
        report_mismatch($sformatf("unexpected result: flow %0d valve %0d pump %0b",
                                  got.flow_target, got.valve_drive, got.pump_on));
      end else begin
        want = expected_commands.pop_front();
        compared++;
        if (got.flow_target !== want.flow_target)
          report_mismatch($sformatf("result %0d flow_target: got %0d, want %0d",
                                    compared, got.flow_target, want.flow_target));
        if (got.valve_drive !== want.valve_drive)
          report_mismatch($sformatf("result %0d valve_drive: got %0d, want %0d",
                                    compared, got.valve_drive, want.valve_drive));
        if (got.pump_on !== want.pump_on)
          report_mismatch($sformatf("result %0d pump_on: got %0b, want %0b",
                                    compared, got.pump_on, want.pump_on));
      end
    endtask
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [TEMP_W-1:0] in_room_target;
  logic signed [TEMP_W-1:0] in_outdoor_now;
  logic signed [TEMP_W-1:0] in_outdoor_mean;
  logic signed [TEMP_W-1:0] in_flow_measured;
  logic                     in_reduced_mode;
  logic                     in_party_active;
  logic signed [TEMP_W-1:0] in_frost_threshold;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [TEMP_W-1:0] out_flow_target;
  logic [VALVE_W-1:0]       out_valve_drive;
  logic                     out_pump_on;

  flow_command_scoreboard board = new();

  bit sender_gaps_on;
  bit receiver_stalls_on;
  int samples_sent;
  int settings_used;

  heating_circuit_flow_controller_unit #(
    .Y_LOW (VALVE_LOW),
    .Y_HIGH(VALVE_HIGH)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_room_target    (in_room_target),
    .in_outdoor_now    (in_outdoor_now),
    .in_outdoor_mean   (in_outdoor_mean),
    .in_flow_measured  (in_flow_measured),
    .in_reduced_mode   (in_reduced_mode),
    .in_party_active   (in_party_active),
    .in_frost_threshold(in_frost_threshold),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_flow_target   (out_flow_target),
    .out_valve_drive   (out_valve_drive),
    .out_pump_on       (out_pump_on)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case a transaction never completes.
  initial begin
    #(TIMEOUT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: hold out_ready high for a while and, with stalls on, now and then drop it briefly.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (receiver_stalls_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(0, 12)) @(posedge clk);
    end
  end

  // Sample the result channel before this edge's updates land.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_result('{out_flow_target, out_valve_drive, out_pump_on});
    end
  end

  function automatic sample_t sample_of(int room, int outdoor, int mean, int flow,
                                        bit reduced, bit party, int frost);
    sample_t s;
    s.room_target     = room[TEMP_W-1:0];
    s.outdoor_now     = outdoor[TEMP_W-1:0];
    s.outdoor_mean    = mean[TEMP_W-1:0];
    s.flow_measured   = flow[TEMP_W-1:0];
    s.reduced_mode    = reduced;
    s.party_active    = party;
    s.frost_threshold = frost[TEMP_W-1:0];
    return s;
  endfunction

  // Present one sample and hold it until the block takes it; valid stays high
  // afterwards unless the next call opens a gap.
  task automatic send_sample(sample_t s);
    if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_room_target     <= s.room_target;
    in_outdoor_now     <= s.outdoor_now;
    in_outdoor_mean    <= s.outdoor_mean;
    in_flow_measured   <= s.flow_measured;
    in_reduced_mode    <= s.reduced_mode;
    in_party_active    <= s.party_active;
    in_frost_threshold <= s.frost_threshold;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_sample(s);
    samples_sent++;
  endtask

  // Drop valid first so the last sample is not taken a second time.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.expected_commands.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Write all eight registers back to back, one per edge, and mirror them.
  task automatic program_registers(cfg_t c);
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    for (int k = 0; k < 8; k++) begin
      idx = CFG_IDX_W'(k);
      case (idx)
        CFG_CURVE_SLOPE:    data = {5'd0, c.curve_slope};
        CFG_CURVE_LEVEL:    data = {c.curve_level[15], c.curve_level};
        CFG_SETBACK_AMOUNT: data = {2'd0, c.setback_amount};
        CFG_FLOW_MIN:       data = {c.flow_min[15], c.flow_min};
        CFG_FLOW_MAX:       data = {c.flow_max[15], c.flow_max};
        CFG_START_OUTDOOR:  data = {c.start_outdoor[15], c.start_outdoor};
        CFG_GAIN_NOW:       data = {1'b0, c.gain_now};
        default:            data = c.gain_prev;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= data;
      board.set_register(idx, data);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Random samples: plausible ones sit near the pump threshold and the usual
  // heating range so the hysteresis and the PI loop get exercised; the rest
  // are raw bits across the full field range.
  task automatic run_phase(bit write_regs, cfg_t c, int count, bit plausible);
    sample_t s;
    int      m;
    int      share;
    if (write_regs) program_registers(c);
    share = plausible ? 80 : 30;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < share) begin
        m = int'(board.regs.start_outdoor) + int'($urandom_range(0, 96)) - 48;
        if (m > 32767)  m = 32767;
        if (m < -32768) m = -32768;
        s = sample_of(int'($urandom_range(256, 384)), int'($urandom_range(0, 800)) - 400,
                      m, int'($urandom_range(160, 1280)), $urandom_range(0, 1),
                      $urandom_range(0, 1), int'($urandom_range(0, 128)) - 64);
      end else begin
        s = sample_t'({$urandom(), $urandom(), $urandom()});
      end
      send_sample(s);
    end
    wait_drained();
  endtask

  initial begin
    cfg_t c;
    bit   plausible;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_wdata          <= '0;
    in_valid           <= 1'b0;
    in_room_target     <= '0;
    in_outdoor_now     <= '0;
    in_outdoor_mean    <= '0;
    in_flow_measured   <= '0;
    in_reduced_mode    <= 1'b0;
    in_party_active    <= 1'b0;
    in_frost_threshold <= '0;
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b1;
    samples_sent       = 0;
    settings_used      = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Run on the reset defaults first.
    run_phase(1'b0, board.regs, 40, 1'b1);

    // Directed samples on a mid-range setting with a real setback.
    c = {12'd384, 16'd32, 15'd160, 16'd320, 16'd1200, 16'd256, 16'd512, -17'sd448};
    program_registers(c);
    send_sample(sample_of(320, -160, 0, 400, 0, 0, 0));
    send_sample(sample_of(320, -160, 0, 400, 1, 0, 0));   // setback applied
    send_sample(sample_of(320, -160, 0, 400, 1, 1, 0));   // party suspends setback
    send_sample(sample_of(320, -160, 0, 400, 0, 1, 0));
    // field extremes: clamp to both flow limits, drive the valve to both rails
    send_sample(sample_of(32767, -32768, -32768, -32768, 1, 0, -32768));
    send_sample(sample_of(-32768, 32767, 32767, 32767, 0, 0, 32767));
    send_sample(sample_of(-32768, -32768, -32768, 32767, 1, 1, 32767));
    send_sample(sample_of(32767, 32767, 32767, -32768, 0, 1, -32768));
    // pump hysteresis edges around start_outdoor = 256
    send_sample(sample_of(320, 100, 272, 800, 0, 0, 0));  // top of band, hold off
    send_sample(sample_of(320, -100, 272, 800, 0, 0, 0)); // frost override
    send_sample(sample_of(320, 100, 273, 800, 0, 0, 0));  // just above band, off
    send_sample(sample_of(320, 100, 256, 800, 0, 0, 0));  // equal to start, hold
    send_sample(sample_of(320, 100, 255, 800, 0, 0, 0));  // below start, hot flow
    send_sample(sample_of(200, 200, 255, 400, 1, 0, -32768)); // cool flow, hold on
    send_sample(sample_of(200, 200, 300, 400, 0, 0, 32767));
    send_sample(sample_of(0, 0, 0, 0, 0, 0, 0));
    send_sample(sample_of(-1, -1, -1, -1, 1, 1, -1));
    send_sample(sample_of(21845, -21846, 21845, -21846, 0, 1, 21845));
    send_sample(sample_of(-21846, 21845, -21846, 21845, 1, 0, -21846));
    send_sample(sample_of(320, 320, 0, 352, 0, 0, 0));    // zero error
    wait_drained();

    // Register extremes: most at the top with the widest flow limits, then everything at the bottom
    // with the flow limits crossed.
    run_phase(1'b1, {12'd4095, 16'h7FFF, 15'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
                     16'hFFFF, 17'h10001}, 60, 1'b0);
    run_phase(1'b1, {12'd0, 16'h8000, 15'd0, 16'h7FFF, 16'h8000, 16'h8000,
                     16'd0, 17'h10000}, 60, 1'b0);
    // Positive previous-error gain and crossed flow limits in a normal setting.
    run_phase(1'b1, {12'd300, 16'd16, 15'd96, 16'd900, 16'd600, 16'd256,
                     16'd1024, 17'h0FFFF}, 60, 1'b1);

    for (int p = 0; p < 11; p++) begin
      plausible = (p % 2 == 0);
      // no idling every fourth phase, and none at all in the final one
      sender_gaps_on     = (p % 4 != 3) && (p != 10);
      receiver_stalls_on = sender_gaps_on;
      if (plausible) begin
        c.curve_slope    = 12'($urandom_range(128, 640));
        c.curve_level    = 16'(int'($urandom_range(0, 128)) - 64);
        c.setback_amount = 15'($urandom_range(0, 160));
        c.flow_min       = 16'($urandom_range(160, 480));
        c.flow_max       = 16'($urandom_range(800, 1280));
        c.start_outdoor  = 16'($urandom_range(160, 320));
        c.gain_now       = 16'($urandom_range(0, 2048));
        c.gain_prev      = 17'(-int'($urandom_range(0, 2048)));
      end else begin
        c.curve_slope    = 12'($urandom_range(0, 4095));
        c.curve_level    = 16'($urandom());
        c.setback_amount = 15'($urandom());
        c.flow_min       = 16'($urandom());
        c.flow_max       = 16'($urandom());
        c.start_outdoor  = 16'($urandom());
        c.gain_now       = 16'($urandom());
        c.gain_prev      = 17'(-int'($urandom_range(0, 65535)));
      end
      run_phase(1'b1, c, 119, plausible);
    end

    in_valid <= 1'b0;
    wait_drained();
    if (board.expected_commands.size() != 0)
      board.report_mismatch($sformatf("%0d results never arrived",
                                      board.expected_commands.size()));
    $display("Sent %0d samples over %0d register settings, compared %0d results.",
             samples_sent, settings_used, board.compared);
    $display("Random idling on both channels in most phases, none in the final one.");
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
